// ===== rtl/kdlr_pkg.sv =====
// kdlr_pkg: shared types and constants for the keypad debounce block.
// Holds the key indexes, register map, config bundle and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package kdlr_pkg;

	// Key set
	localparam int NUM_KEYS  = 10;
	localparam int KEY_IDX_W = 4;
	localparam int CODE_W    = 5;
	localparam int CFG_W     = 16;

	localparam logic [KEY_IDX_W-1:0] MENU_BTN   = 4'd0;
	localparam logic [KEY_IDX_W-1:0] SELECT_BTN = 4'd9;
	localparam logic [KEY_IDX_W-1:0] KEY_LAST   = 4'd9;

	// First digit code; digit d is reported as DIGIT_BASE + d
	localparam logic [CODE_W-1:0] DIGIT_BASE = 5'd10;

	// Register map (word index)
	localparam int REG_IDX_W = 3;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEBOUNCE     = 3'd0,
		REG_LONG_PRESS   = 3'd1,
		REG_REPEAT_DELAY = 3'd2,
		REG_REPEAT_INTVL = 3'd3,
		REG_REPEAT_MASK  = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]    debounce_time;
		logic [CFG_W-1:0]    long_press_time;
		logic [CFG_W-1:0]    repeat_delay;
		logic [CFG_W-1:0]    repeat_interval;
		logic [NUM_KEYS-1:0] repeat_mask;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;
		logic last_key;
		logic slot_free;
	} sts_t;

	// One result word
	typedef struct packed {
		logic              event_valid;
		logic [CODE_W-1:0] key_code;
		logic              long_press;
		logic              auto_repeat;
		logic              numeric_state;
	} result_t;

endpackage

// ===== rtl/keypad_debounce_long_repeat.sv =====
// keypad_debounce_long_repeat: top level of the ten-key debouncer with long press and repeat.
// Depends on kdlr_pkg, kdlr_regs, kdlr_ctrl and kdlr_datapath.
//
//   channel | handshake           | word
//   --------+---------------------+------------------------------------------------
//   in      | in_valid / in_stall | now_ms, raw_levels, editor_active
//   out     | out_valid/out_stall | event_valid, key_code, long_press, auto_repeat,
//           |                     | numeric_state
//   config  | APB psel/penable    | paddr 4*i, pwdata / prdata, pready tied high
//
// A poll loads the inputs, visits one key per cycle (1 to 10 keys, stopping at the first
// event), then moves the result into the output register.
// The key scan is the one shared compare unit stepping over the per-key state.
// Reset releases all keys, clears all times and turns numeric mode off.
// in_stall is high from the load until the result reaches the output register; a
// stalled output only delays that last move while a finished result is held.
`timescale 1ns / 1ps

module keypad_debounce_long_repeat #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Poll input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [31:0]                   now_ms,
	input  logic [kdlr_pkg::NUM_KEYS-1:0] raw_levels,
	input  logic                          editor_active,
	// Event output
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          event_valid,
	output logic [kdlr_pkg::CODE_W-1:0]   key_code,
	output logic                          long_press,
	output logic                          auto_repeat,
	output logic                          numeric_state,
	// Configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kdlr_pkg::ADDR_W-1:0]   paddr,
	input  logic [kdlr_pkg::DATA_W-1:0]   pwdata,
	output logic [kdlr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	kdlr_pkg::cfg_t    cfg;
	kdlr_pkg::cmd_t    cmd;
	kdlr_pkg::sts_t    sts;
	kdlr_pkg::result_t out_res;

	kdlr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	kdlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	kdlr_datapath #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg),
		.now_ms        (now_ms),
		.raw_levels    (raw_levels),
		.editor_active (editor_active),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_res       (out_res)
	);

	// Unpack the result word
	assign event_valid   = out_res.event_valid;
	assign key_code      = out_res.key_code;
	assign long_press    = out_res.long_press;
	assign auto_repeat   = out_res.auto_repeat;
	assign numeric_state = out_res.numeric_state;

endmodule

// ===== rtl/kdlr_regs.sv =====
// kdlr_regs: APB-style configuration registers for the keypad debounce block.
// Depends on kdlr_pkg for the register map and config bundle.
`timescale 1ns / 1ps

module kdlr_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kdlr_pkg::ADDR_W-1:0] paddr,
	input  logic [kdlr_pkg::DATA_W-1:0] pwdata,
	output logic [kdlr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output kdlr_pkg::cfg_t             cfg
);

	kdlr_pkg::cfg_t cfg_q;
	kdlr_pkg::reg_idx_t reg_idx;
	logic wr_en;

	assign pready  = 1'b1;
	assign reg_idx = kdlr_pkg::reg_idx_t'(paddr[kdlr_pkg::ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// Write the addressed register; addresses past the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time   <= 16'd20;
			cfg_q.long_press_time <= 16'd600;
			cfg_q.repeat_delay    <= 16'd400;
			cfg_q.repeat_interval <= 16'd120;
			cfg_q.repeat_mask     <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				kdlr_pkg::REG_DEBOUNCE:     cfg_q.debounce_time   <= pwdata[kdlr_pkg::CFG_W-1:0];
				kdlr_pkg::REG_LONG_PRESS:   cfg_q.long_press_time <= pwdata[kdlr_pkg::CFG_W-1:0];
				kdlr_pkg::REG_REPEAT_DELAY: cfg_q.repeat_delay    <= pwdata[kdlr_pkg::CFG_W-1:0];
				kdlr_pkg::REG_REPEAT_INTVL: cfg_q.repeat_interval <= pwdata[kdlr_pkg::CFG_W-1:0];
				kdlr_pkg::REG_REPEAT_MASK:  cfg_q.repeat_mask     <= pwdata[kdlr_pkg::NUM_KEYS-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			kdlr_pkg::REG_DEBOUNCE:     prdata = kdlr_pkg::DATA_W'(cfg_q.debounce_time);
			kdlr_pkg::REG_LONG_PRESS:   prdata = kdlr_pkg::DATA_W'(cfg_q.long_press_time);
			kdlr_pkg::REG_REPEAT_DELAY: prdata = kdlr_pkg::DATA_W'(cfg_q.repeat_delay);
			kdlr_pkg::REG_REPEAT_INTVL: prdata = kdlr_pkg::DATA_W'(cfg_q.repeat_interval);
			kdlr_pkg::REG_REPEAT_MASK:  prdata = kdlr_pkg::DATA_W'(cfg_q.repeat_mask);
			default:                    prdata = '0;
		endcase
	end

endmodule

// ===== rtl/kdlr_datapath.sv =====
// kdlr_datapath: per-key debounce state, one-key evaluation and the result registers.
// Depends on kdlr_pkg; driven by kdlr_ctrl through cmd_t / sts_t.
`timescale 1ns / 1ps

module kdlr_datapath #(
	parameter int TIME_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kdlr_pkg::cmd_t                cmd,
	output kdlr_pkg::sts_t                sts,
	input  kdlr_pkg::cfg_t                cfg,
	input  logic [31:0]                   now_ms,
	input  logic [kdlr_pkg::NUM_KEYS-1:0] raw_levels,
	input  logic                          editor_active,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kdlr_pkg::result_t             out_res
);

	localparam int NK = kdlr_pkg::NUM_KEYS;

	// Captured poll
	logic [TIME_WIDTH-1:0] now_q;
	logic [NK-1:0]         levels_q;
	logic                  editor_q;
	logic [kdlr_pkg::KEY_IDX_W-1:0] idx_q;

	// Per-key state
	logic [NK-1:0]         raw_seen_q;
	logic [NK-1:0]         stable_q;
	logic [NK-1:0]         long_sent_q;
	logic [TIME_WIDTH-1:0] change_q [NK];
	logic [TIME_WIDTH-1:0] press_q  [NK];
	logic [TIME_WIDTH-1:0] lrep_q   [NK];
	logic                  numeric_q;

	// Pending and presented result words
	kdlr_pkg::result_t res_q;
	kdlr_pkg::result_t out_res_q;
	logic              out_valid_q;

	// Evaluation of the current key
	logic                  raw, dual, changed, numeric_edit, is_last;
	logic [TIME_WIDTH-1:0] el_change, el_press, el_rep;
	logic                  deb, rep_due, long_due, rep_fire, long_fire, hit;
	logic [kdlr_pkg::CODE_W-1:0] idx_code, click_code;
	logic                  numeric_next;
	kdlr_pkg::result_t     ev;

	always_comb begin
		raw          = levels_q[idx_q];
		dual         = (idx_q == kdlr_pkg::MENU_BTN) || (idx_q == kdlr_pkg::SELECT_BTN);
		changed      = raw != raw_seen_q[idx_q];
		is_last      = idx_q == kdlr_pkg::KEY_LAST;
		numeric_edit = numeric_q && editor_q;

		// Elapsed times modulo 2^TIME_WIDTH; a fresh raw change restarts at zero
		el_change = changed ? '0 : now_q - change_q[idx_q];
		el_press  = now_q - press_q[idx_q];
		el_rep    = now_q - lrep_q[idx_q];

		deb      = (el_change >= TIME_WIDTH'(cfg.debounce_time)) && (raw != stable_q[idx_q]);
		rep_due  = !stable_q[idx_q] && cfg.repeat_mask[idx_q]
			&& (el_press >= TIME_WIDTH'(cfg.repeat_delay))
			&& (el_rep >= TIME_WIDTH'(cfg.repeat_interval));
		long_due = !stable_q[idx_q] && dual && !long_sent_q[idx_q]
			&& (el_press >= TIME_WIDTH'(cfg.long_press_time));

		// After a settled release the key is stable high, so no repeat or long press follows
		rep_fire  = !deb && rep_due;
		long_fire = !deb && !rep_due && long_due;

		hit = deb ? (!raw || (dual && !long_sent_q[idx_q]))
			: (rep_fire ? !numeric_edit : long_fire);

		idx_code   = kdlr_pkg::CODE_W'(idx_q);
		// Button i maps to digit (i+1) mod 10
		click_code = (idx_q == kdlr_pkg::SELECT_BTN) ? kdlr_pkg::DIGIT_BASE
			: kdlr_pkg::DIGIT_BASE + idx_code + kdlr_pkg::CODE_W'(1);
		if (!numeric_edit)
			click_code = idx_code;

		numeric_next = numeric_q ^ (long_fire && (idx_q == kdlr_pkg::SELECT_BTN));

		ev = '0;
		ev.numeric_state = numeric_next;
		if (hit) begin
			if (deb) begin
				// Dual-role keys stay quiet on press and click on release unless a long press was sent
				ev.event_valid = raw || !dual;
				ev.key_code    = ev.event_valid ? click_code : '0;
			end else begin
				ev.event_valid = 1'b1;
				ev.key_code    = idx_code;
				ev.long_press  = long_fire;
				ev.auto_repeat = rep_fire;
			end
		end
	end

	// Capture the poll
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q    <= now_ms[TIME_WIDTH-1:0];
			levels_q <= raw_levels;
			editor_q <= editor_active;
		end
	end

	// Advance the key index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.step && !is_last) begin
			idx_q <= idx_q + kdlr_pkg::KEY_IDX_W'(1);
		end
	end

	// Update the visited key's state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_seen_q  <= '1;
			stable_q    <= '1;
			long_sent_q <= '0;
			numeric_q   <= 1'b0;
			for (int k = 0; k < NK; k++) begin
				change_q[k] <= '0;
				press_q[k]  <= '0;
				lrep_q[k]   <= '0;
			end
		end else if (cmd.step) begin
			raw_seen_q[idx_q] <= raw;
			if (changed)
				change_q[idx_q] <= now_q;
			if (deb) begin
				stable_q[idx_q] <= raw;
				if (!raw) begin
					press_q[idx_q]     <= now_q;
					lrep_q[idx_q]      <= now_q;
					long_sent_q[idx_q] <= 1'b0;
				end
			end
			if (rep_fire)
				lrep_q[idx_q] <= now_q;
			if (long_fire)
				long_sent_q[idx_q] <= 1'b1;
			numeric_q <= numeric_next;
		end
	end

	// Hold the poll's result until the output slot frees up
	always_ff @(posedge clk) begin
		if (cmd.step && (hit || is_last))
			res_q <= ev;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish)
			out_res_q <= res_q;
	end

	assign out_valid     = out_valid_q;
	assign out_res       = out_res_q;
	assign sts.hit       = hit;
	assign sts.last_key  = is_last;
	assign sts.slot_free = !out_valid_q || !out_stall;

endmodule

// ===== rtl/kdlr_ctrl.sv =====
// kdlr_ctrl: controller state machine sequencing one poll over the ten keys.
// Depends on kdlr_pkg; commands kdlr_datapath through cmd_t / sts_t.
`timescale 1ns / 1ps

module kdlr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output kdlr_pkg::cmd_t cmd,
	input  kdlr_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (sts.hit || sts.last_key)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.slot_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> sts.slot_free)
		else $error("result published into an occupied output slot");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && (sts.hit || sts.last_key)) |=> (state_q == ST_FINISH))
		else $error("scan did not stop at the event or the last key");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.publish}))
		else $error("more than one datapath command at once");

	a_load_scans: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_SCAN) && $past(!in_stall))
		else $error("poll loaded without starting a scan");

endmodule

// ===== bench/keypad_debounce_long_repeat_tb.sv =====
// keypad_debounce_long_repeat_tb: self-checking bench for the ten-key debouncer.
// Drives polls and APB writes, predicts every event word in-bench and compares
// field by field; depends on kdlr_pkg and keypad_debounce_long_repeat.
`timescale 1ns / 1ps

module keypad_debounce_long_repeat_tb;

	localparam int CLK_HALF    = 4;
	localparam int RESET_CYC   = 7;
	localparam int DRAIN_CYC   = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_POLLS = 150;
	localparam int DIR_ROWS    = 34;

	// Unmapped register slot, written once in the directed table
	localparam logic [kdlr_pkg::REG_IDX_W-1:0] REG_SPARE = 3'd5;

	typedef enum logic {ROW_POLL, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                          kind;
		logic                               checked;
		logic [31:0]                        at_ms;
		logic [kdlr_pkg::NUM_KEYS-1:0]      levels;
		logic                               editor;
		kdlr_pkg::result_t                  want;
		logic [kdlr_pkg::REG_IDX_W-1:0]     reg_at;
		logic [31:0]                        reg_val;
	} stim_row_t;

	localparam kdlr_pkg::result_t NO_EVENT = '0;
	localparam kdlr_pkg::result_t CLICK_UP = '{1'b1, 5'd1, 1'b0, 1'b0, 1'b0};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] now_ms;
	logic [kdlr_pkg::NUM_KEYS-1:0] raw_levels;
	logic editor_active;
	logic out_valid;
	logic out_stall;
	logic event_valid;
	logic [kdlr_pkg::CODE_W-1:0] key_code;
	logic long_press;
	logic auto_repeat;
	logic numeric_state;
	logic psel;
	logic penable;
	logic pwrite;
	logic [kdlr_pkg::ADDR_W-1:0] paddr;
	logic [kdlr_pkg::DATA_W-1:0] pwdata;
	logic [kdlr_pkg::DATA_W-1:0] prdata;
	logic pready;

	keypad_debounce_long_repeat dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.raw_levels(raw_levels),
		.editor_active(editor_active),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_valid(event_valid),
		.key_code(key_code),
		.long_press(long_press),
		.auto_repeat(auto_repeat),
		.numeric_state(numeric_state),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Key tracker state and live register copy
	kdlr_pkg::cfg_t                live_cfg;
	logic [kdlr_pkg::NUM_KEYS-1:0] pin_prev;
	logic [kdlr_pkg::NUM_KEYS-1:0] lvl_stable;
	logic [kdlr_pkg::NUM_KEYS-1:0] long_sent;
	logic [31:0]                   edge_ms [kdlr_pkg::NUM_KEYS];
	logic [31:0]                   down_ms [kdlr_pkg::NUM_KEYS];
	logic [31:0]                   rep_ms [kdlr_pkg::NUM_KEYS];
	logic                          digit_mode;

	kdlr_pkg::result_t pending_events [$];
	int      fail_count = 0;
	int      words_seen = 0;
	int      snd_idle_pct = 0;
	int      rcv_stall_pct = 0;
	int      quiet_cycles = 0;

	// Directed walk: typed expectations only where obvious, else the tracker decides
	stim_row_t dir_table [DIR_ROWS] = '{
		'{ROW_POLL, 1'b1, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b1, 32'hFFFF_FFFF, 10'h3FF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		// Up goes down, then settles into a click
		'{ROW_POLL, 1'b1, 32'd100,       10'h3FD, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b1, 32'd120,       10'h3FD, 1'b0, CLICK_UP,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd140,       10'h3FD, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		// Select held: silent press, then long press toggles digit mode
		'{ROW_POLL, 1'b0, 32'd200,       10'h1FD, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b1, 32'd220,       10'h1FD, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd820,       10'h1FD, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd830,       10'h3FF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd850,       10'h3FF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		// Menu tap in digit mode clicks on release as a digit
		'{ROW_POLL, 1'b0, 32'd900,       10'h3FE, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd920,       10'h3FE, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd950,       10'h3FF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd970,       10'h3FF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1000,      10'h3EF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1020,      10'h3EF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		// Repeat on every key: held back in digit mode, then reported
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_REPEAT_MASK, 32'hFFFF_FFFF},
		'{ROW_POLL, 1'b0, 32'd1500,      10'h3EF, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1620,      10'h3EF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		// All times zero: every condition is met at once
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_LONG_PRESS, 32'd0},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_REPEAT_DELAY, 32'd0},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_REPEAT_INTVL, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1621,      10'h000, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1621,      10'h000, 1'b1, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1621,      10'h000, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		// Spare slot ignored; oversize values clipped to width; times at max
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT, REG_SPARE, 32'h1234},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'hFFFF_FFFF},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_LONG_PRESS, 32'hFFFF},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_REPEAT_DELAY, 32'hFFFF},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_REPEAT_INTVL, 32'hFFFF},
		'{ROW_CFG,  1'b0, 32'd0,         10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_REPEAT_MASK, 32'd0},
		'{ROW_POLL, 1'b0, 32'd1700,      10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0},
		'{ROW_POLL, 1'b0, 32'd67235,     10'h3FF, 1'b0, NO_EVENT,
			kdlr_pkg::REG_DEBOUNCE, 32'd0}
	};

	// Clear the tracker to its power-up state
	task automatic clear_tracker();
		live_cfg.debounce_time   = 16'd20;
		live_cfg.long_press_time = 16'd600;
		live_cfg.repeat_delay    = 16'd400;
		live_cfg.repeat_interval = 16'd120;
		live_cfg.repeat_mask     = '0;
		pin_prev   = '1;
		lvl_stable = '1;
		long_sent  = '0;
		digit_mode = 1'b0;
		for (int k = 0; k < kdlr_pkg::NUM_KEYS; k++) begin
			edge_ms[k] = '0;
			down_ms[k] = '0;
			rep_ms[k]  = '0;
		end
	endtask

	function automatic logic [kdlr_pkg::CODE_W-1:0] key_or_digit(int k, logic ed);
		if (digit_mode && ed)
			return kdlr_pkg::DIGIT_BASE + kdlr_pkg::CODE_W'((k + 1) % 10);
		return kdlr_pkg::CODE_W'(k);
	endfunction

	// Scan keys in priority order; the first event ends the poll
	function automatic kdlr_pkg::result_t poll_event(logic [31:0] t,
	                                                 logic [kdlr_pkg::NUM_KEYS-1:0] lv,
	                                                 logic ed);
		kdlr_pkg::result_t r;
		logic    pin;
		logic    two_way;
		int      k;
		r = '0;
		for (k = 0; k < kdlr_pkg::NUM_KEYS; k++) begin
			pin = lv[k];
			two_way = (k == kdlr_pkg::MENU_BTN) || (k == kdlr_pkg::SELECT_BTN);
			if (pin != pin_prev[k]) begin
				pin_prev[k] = pin;
				edge_ms[k] = t;
			end
			// Debounced transition
			if ((t - edge_ms[k]) >= live_cfg.debounce_time && pin != lvl_stable[k]) begin
				lvl_stable[k] = pin;
				if (!pin) begin
					down_ms[k] = t;
					rep_ms[k] = t;
					long_sent[k] = 1'b0;
					if (!two_way) begin
						r.event_valid = 1'b1;
						r.key_code = key_or_digit(k, ed);
					end
					r.numeric_state = digit_mode;
					return r;
				end
				if (two_way && !long_sent[k]) begin
					r.event_valid = 1'b1;
					r.key_code = key_or_digit(k, ed);
					r.numeric_state = digit_mode;
					return r;
				end
			end
			// Repeat due; a held-back repeat also skips the long check
			if (!lvl_stable[k] && live_cfg.repeat_mask[k] &&
			    (t - down_ms[k]) >= live_cfg.repeat_delay &&
			    (t - rep_ms[k]) >= live_cfg.repeat_interval) begin
				rep_ms[k] = t;
				if (!(digit_mode && ed)) begin
					r.event_valid = 1'b1;
					r.key_code = kdlr_pkg::CODE_W'(k);
					r.auto_repeat = 1'b1;
					r.numeric_state = digit_mode;
					return r;
				end
			end else if (!lvl_stable[k] && two_way && !long_sent[k] &&
			             (t - down_ms[k]) >= live_cfg.long_press_time) begin
				long_sent[k] = 1'b1;
				if (k == kdlr_pkg::SELECT_BTN)
					digit_mode = ~digit_mode;
				r.event_valid = 1'b1;
				r.key_code = kdlr_pkg::CODE_W'(k);
				r.long_press = 1'b1;
				r.numeric_state = digit_mode;
				return r;
			end
		end
		r.numeric_state = digit_mode;
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		fail_count++;
		$display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	// Offer one poll word and log its expected event once accepted
	task automatic send_poll(logic [31:0] t, logic [kdlr_pkg::NUM_KEYS-1:0] lv, logic ed,
	                         logic checked, kdlr_pkg::result_t want);
		kdlr_pkg::result_t guess;
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		raw_levels <= lv;
		editor_active <= ed;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		guess = poll_event(t, lv, ed);
		pending_events.push_back(checked ? want : guess);
	endtask

	// Drop valid and wait until every expected word is back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// APB write, then read back mapped registers
	task automatic write_reg(logic [kdlr_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
		logic [31:0] want;
		logic        mapped;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		mapped = 1'b1;
		case (kdlr_pkg::reg_idx_t'(idx))
			kdlr_pkg::REG_DEBOUNCE:
				live_cfg.debounce_time = val[kdlr_pkg::CFG_W-1:0];
			kdlr_pkg::REG_LONG_PRESS:
				live_cfg.long_press_time = val[kdlr_pkg::CFG_W-1:0];
			kdlr_pkg::REG_REPEAT_DELAY:
				live_cfg.repeat_delay = val[kdlr_pkg::CFG_W-1:0];
			kdlr_pkg::REG_REPEAT_INTVL:
				live_cfg.repeat_interval = val[kdlr_pkg::CFG_W-1:0];
			kdlr_pkg::REG_REPEAT_MASK:
				live_cfg.repeat_mask = val[kdlr_pkg::NUM_KEYS-1:0];
			default:
				mapped = 1'b0;
		endcase
		@(negedge clk);
		if (!mapped) begin
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
		end else begin
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			case (kdlr_pkg::reg_idx_t'(idx))
				kdlr_pkg::REG_DEBOUNCE:     want = 32'(live_cfg.debounce_time);
				kdlr_pkg::REG_LONG_PRESS:   want = 32'(live_cfg.long_press_time);
				kdlr_pkg::REG_REPEAT_DELAY: want = 32'(live_cfg.repeat_delay);
				kdlr_pkg::REG_REPEAT_INTVL: want = 32'(live_cfg.repeat_interval);
				default:                    want = 32'(live_cfg.repeat_mask);
			endcase
			if (prdata !== want)
				flag_mismatch("register readback", prdata, want);
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	// Receiver stalls at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	// Compare each accepted event word with the oldest expectation
	always @(posedge clk) begin : event_check
		kdlr_pkg::result_t got;
		kdlr_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {event_valid, key_code, long_press, auto_repeat, numeric_state};
			words_seen++;
			if (pending_events.size() == 0) begin
				flag_mismatch("unexpected event word", words_seen, 32'd0);
			end else begin
				want = pending_events.pop_front();
				if (got.event_valid !== want.event_valid)
					flag_mismatch("event_valid", 32'(got.event_valid),
					              32'(want.event_valid));
				if (got.key_code !== want.key_code)
					flag_mismatch("key_code", 32'(got.key_code), 32'(want.key_code));
				if (got.long_press !== want.long_press)
					flag_mismatch("long_press", 32'(got.long_press), 32'(want.long_press));
				if (got.auto_repeat !== want.auto_repeat)
					flag_mismatch("auto_repeat", 32'(got.auto_repeat),
					              32'(want.auto_repeat));
				if (got.numeric_state !== want.numeric_state)
					flag_mismatch("numeric_state", 32'(got.numeric_state),
					              32'(want.numeric_state));
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int                            p;
		int                            n;
		int                            roll;
		int                            kk;
		logic [31:0]                   ms;
		logic [kdlr_pkg::NUM_KEYS-1:0] held;
		logic [kdlr_pkg::NUM_KEYS-1:0] lv;
		logic                          ed;

		arst_n = 1'b0;
		in_valid = 1'b0;
		now_ms = '0;
		raw_levels = '1;
		editor_active = 1'b0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		clear_tracker();
		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		snd_idle_pct = 25;
		rcv_stall_pct = 47;

		// Directed table
		for (n = 0; n < DIR_ROWS; n++) begin
			if (dir_table[n].kind == ROW_CFG) begin
				settle();
				write_reg(dir_table[n].reg_at, dir_table[n].reg_val);
			end else begin
				send_poll(dir_table[n].at_ms, dir_table[n].levels, dir_table[n].editor,
				          dir_table[n].checked, dir_table[n].want);
			end
		end

		// Random phases: receiver stalls more, then sender idles more, then nobody
		held = '0;
		ed = 1'b0;
		for (p = 0; p < 3; p++) begin
			settle();
			case (p)
				0: begin
					snd_idle_pct = 25;
					rcv_stall_pct = 47;
					write_reg(kdlr_pkg::REG_DEBOUNCE, $urandom_range(0, 8));
					write_reg(kdlr_pkg::REG_LONG_PRESS, $urandom_range(20, 120));
					write_reg(kdlr_pkg::REG_REPEAT_DELAY, $urandom_range(10, 80));
					write_reg(kdlr_pkg::REG_REPEAT_INTVL, $urandom_range(0, 30));
					write_reg(kdlr_pkg::REG_REPEAT_MASK, $urandom);
					ms = $urandom;
				end
				1: begin
					snd_idle_pct = 47;
					rcv_stall_pct = 25;
					write_reg(kdlr_pkg::REG_DEBOUNCE, $urandom_range(1, 30));
					write_reg(kdlr_pkg::REG_LONG_PRESS, $urandom_range(50, 400));
					write_reg(kdlr_pkg::REG_REPEAT_DELAY, $urandom_range(20, 200));
					write_reg(kdlr_pkg::REG_REPEAT_INTVL, $urandom_range(5, 60));
					write_reg(kdlr_pkg::REG_REPEAT_MASK, $urandom);
					// Start just short of the wrap
					ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
				end
				default: begin
					snd_idle_pct = 0;
					rcv_stall_pct = 0;
					write_reg(kdlr_pkg::REG_DEBOUNCE, 32'd0);
					write_reg(kdlr_pkg::REG_LONG_PRESS, 32'hFFFF);
					write_reg(kdlr_pkg::REG_REPEAT_DELAY, 32'hFFFF);
					write_reg(kdlr_pkg::REG_REPEAT_INTVL, 32'd0);
					write_reg(kdlr_pkg::REG_REPEAT_MASK, 32'h3FF);
					ms = $urandom;
				end
			endcase
			for (n = 0; n < PHASE_POLLS; n++) begin
				// Advance time: mostly small steps, sometimes long holds or a jump
				roll = int'($urandom_range(99));
				if (roll < 70)
					ms = ms + $urandom_range(0, 25);
				else if (roll < 92)
					ms = ms + $urandom_range(0, 800);
				else if (roll < 98)
					ms = ms + $urandom_range(0, 70000);
				else
					ms = $urandom;
				// Press or release a key, favoring Menu and Select
				if ($urandom_range(99) < 14) begin
					if ($urandom_range(99) < 30)
						kk = $urandom_range(1) ? int'(kdlr_pkg::SELECT_BTN)
							: int'(kdlr_pkg::MENU_BTN);
					else
						kk = int'($urandom_range(kdlr_pkg::NUM_KEYS - 1));
					held[kk] = ~held[kk];
				end
				if ($urandom_range(99) < 5)
					ed = ~ed;
				lv = ~held;
				// Occasional contact bounce
				if ($urandom_range(99) < 6)
					lv = lv ^ kdlr_pkg::NUM_KEYS'($urandom);
				send_poll(ms, lv, ed, 1'b0, NO_EVENT);
			end
		end

		settle();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/kdlr_pkg.sv
rtl/kdlr_regs.sv
rtl/kdlr_datapath.sv
rtl/kdlr_ctrl.sv
rtl/keypad_debounce_long_repeat.sv
bench/keypad_debounce_long_repeat_tb.sv
